FILE: design/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg - shared types and constants of the hex bitmap decoder
// Field widths, configuration register indexes, character codes, the command
// word passed from front to back, and the hex digit decoder.
// ----------------------------------------------------------------------------
package bhd_pkg;

	localparam int BYTE_W   = 8;
	localparam int CH_W     = 8;
	localparam int WIDTH_W  = 9;
	localparam int HEIGHT_W = 8;
	localparam int TOTAL_W  = 13;
	localparam int BIR_W    = 6;   // byte position in a row
	localparam int CNT_W    = 7;   // holds a padded stride of up to 64 bytes
	localparam int TDATA_W  = 24;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd8;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd16;

	localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
	localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;

	// one command: count copies of data, flags and total only on the final one
	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [BYTE_W-1:0]  data;
		logic               fin;
		logic               blank;
		logic               error;
		logic [TOTAL_W-1:0] total;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(logic [CH_W-1:0] c);
		hex_t r;
		r.valid = 1'b1;
		r.value = 4'd0;
		priority if (c >= CH_ZERO && c <= CH_NINE) begin
			r.value = 4'(c - CH_ZERO);
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			r.value = 4'(c - CH_UPPER_A + 8'd10);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			r.value = 4'(c - CH_LOWER_A + 8'd10);
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: design/bdf_hex_bitmap_decoder.sv
// ----------------------------------------------------------------------------
// bdf_hex_bitmap_decoder - glyph bitmap text to padded byte rows
// Turns the hex text of a glyph bitmap into rows of bytes at a padded stride.
// ----------------------------------------------------------------------------
// Input stream s_*: one character a cycle, tuser marks the first character of
// a glyph and clears the parse state. Output stream m_*: one byte a cycle,
// tlast on the final byte of a glyph or on an error result, tuser carries the
// blank and error flags, tdata the byte and (on the final byte) the total.
// The cfg port sets glyph width and height; write it only between glyphs.
// A result passes through the command queue and the output register. Characters
// are taken one a cycle while the four-entry command queue has room; a newline
// becomes at most one queued run of zero bytes that the sequencer sends at one
// byte a cycle while m_tready allows, so padding runs hold up the output and the
// input stalls once the queue is full. An output stall holds the result in the
// output register and backs up through the queue to s_tready.
// Reset loads width 8 and height 16, clears the parse state and empties the
// queue; no result is pending after it.
// ----------------------------------------------------------------------------
module bdf_hex_bitmap_decoder #(
	parameter int MAX_ROW_BYTES = 32,
	parameter int STRIDE_ALIGN  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bhd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bhd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bhd_pkg::CH_W-1:0]         s_tdata,   // ch
	input  logic                             s_tuser,   // first
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bhd_pkg::TDATA_W-1:0]      m_tdata,   // out_byte, total_bytes
	output logic                             m_tlast,
	output logic [1:0]                       m_tuser    // blank, error
);

	logic          q_full;
	logic          q_empty;
	logic          push;
	logic          pop;
	bhd_pkg::cmd_t cmd;
	bhd_pkg::cmd_t head;

	assign s_tready = !q_full;

	bhd_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.STRIDE_ALIGN (STRIDE_ALIGN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.accept   (s_tvalid && s_tready),
		.ch       (s_tdata),
		.first    (s_tuser),
		.push     (push),
		.cmd      (cmd)
	);

	bhd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	bhd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

FILE: design/bhd_front.sv
// ----------------------------------------------------------------------------
// bhd_front - character parser
// Holds the glyph geometry registers and the row parse state, takes one
// character a cycle and turns it into at most one command for the back end.
// ----------------------------------------------------------------------------
module bhd_front #(
	parameter int MAX_ROW_BYTES = 32,
	parameter int STRIDE_ALIGN  = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bhd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bhd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             accept,
	input  logic [bhd_pkg::CH_W-1:0]         ch,
	input  logic                             first,
	output logic                             push,
	output bhd_pkg::cmd_t                    cmd
);

	localparam int RB_W    = $clog2(MAX_ROW_BYTES + 1);
	localparam int RB_SPAN = 2 ** RB_W;
	localparam int CW      = bhd_pkg::CNT_W;
	localparam int BW      = bhd_pkg::BIR_W;
	localparam int HW      = bhd_pkg::HEIGHT_W;
	localparam int TW      = bhd_pkg::TOTAL_W;

	logic [bhd_pkg::WIDTH_W-1:0] width_q;
	logic [HW-1:0]               height_q;
	logic [HW-1:0]               row_q;
	logic [BW-1:0]               bir_q;
	logic [3:0]                  nib_q;
	logic                        have_q;
	logic                        any_q;
	logic                        err_q;

	logic [HW-1:0] row_c, row_n;
	logic [BW-1:0] bir_c, bir_n, bir_inc;
	logic [3:0]    nib_c, nib_n;
	logic          have_c, have_n;
	logic          any_c, any_n;
	logic          err_c, err_n;

	logic [bhd_pkg::WIDTH_W:0] width_sum;
	logic [CW-1:0]             rb_raw;
	logic [RB_W-1:0]           rb;
	logic [CW-1:0]             stride_tab [RB_SPAN];
	logic [CW-1:0]             stride;
	logic [HW+CW-1:0]          product;
	logic [TW-1:0]             total;
	logic                      idle;
	logic                      last_row;
	logic [CW-1:0]             bir_ext;
	logic [CW-1:0]             remaining;
	bhd_pkg::hex_t             hex;
	logic [7:0]                value;
	logic                      any_byte;
	logic                      fin_byte;

	// padded stride for every row byte count
	for (genvar g = 0; g < RB_SPAN; g++) begin : g_stride
		assign stride_tab[g] = CW'(((g + STRIDE_ALIGN - 1) / STRIDE_ALIGN) * STRIDE_ALIGN);
	end

	always_comb begin
		width_sum = {1'b0, width_q} + 10'd7;
		rb_raw    = CW'(width_sum >> 3);
		priority if (rb_raw == '0) begin
			rb = RB_W'(1);
		end else if (rb_raw > CW'(MAX_ROW_BYTES)) begin
			rb = RB_W'(MAX_ROW_BYTES);
		end else begin
			rb = RB_W'(rb_raw);
		end
		stride  = stride_tab[rb];
		product = height_q * stride;
		total   = product[TW-1:0];
	end

	// a first character clears the parse state before it is handled
	always_comb begin
		row_c  = first ? '0 : row_q;
		bir_c  = first ? '0 : bir_q;
		nib_c  = first ? '0 : nib_q;
		have_c = first ? 1'b0 : have_q;
		any_c  = first ? 1'b0 : any_q;
		err_c  = first ? 1'b0 : err_q;

		idle      = err_c || (row_c >= height_q);
		last_row  = ({1'b0, row_c} + 9'd1) == {1'b0, height_q};
		bir_ext   = {1'b0, bir_c};
		remaining = (bir_ext < stride) ? stride - bir_ext : '0;
		bir_inc   = bir_c + BW'(1);
		hex       = bhd_pkg::hex_decode(ch);
		value     = {nib_c, hex.value};
		any_byte  = any_c || (value != 8'h00);
		fin_byte  = last_row && ({1'b0, bir_inc} >= stride);

		row_n  = row_c;
		bir_n  = bir_c;
		nib_n  = nib_c;
		have_n = have_c;
		any_n  = any_c;
		err_n  = err_c;

		push      = 1'b0;
		cmd.count = CW'(1);
		cmd.data  = '0;
		cmd.fin   = 1'b0;
		cmd.blank = 1'b0;
		cmd.error = 1'b0;
		cmd.total = '0;

		if (accept && !idle) begin
			priority if (ch == bhd_pkg::CH_NEWLINE && have_c) begin
				// odd digit count
				err_n     = 1'b1;
				have_n    = 1'b0;
				push      = 1'b1;
				cmd.fin   = 1'b1;
				cmd.error = 1'b1;
			end else if (ch == bhd_pkg::CH_NEWLINE) begin
				push      = (remaining != '0);
				cmd.count = remaining;
				cmd.fin   = last_row;
				cmd.blank = last_row && !any_c;
				cmd.total = last_row ? total : '0;
				row_n     = row_c + HW'(1);
				bir_n     = '0;
			end else if (bir_ext >= CW'(rb)) begin
				// extra characters past the row width are skipped
			end else if (!hex.valid) begin
				err_n     = 1'b1;
				have_n    = 1'b0;
				push      = 1'b1;
				cmd.fin   = 1'b1;
				cmd.error = 1'b1;
			end else if (!have_c) begin
				nib_n  = hex.value;
				have_n = 1'b1;
			end else begin
				have_n    = 1'b0;
				any_n     = any_byte;
				push      = 1'b1;
				cmd.data  = value;
				cmd.fin   = fin_byte;
				cmd.blank = fin_byte && !any_byte;
				cmd.total = fin_byte ? total : '0;
				row_n     = fin_byte ? row_c + HW'(1) : row_c;
				bir_n     = fin_byte ? '0 : bir_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bhd_pkg::WIDTH_RESET;
			height_q <= bhd_pkg::HEIGHT_RESET;
			row_q    <= '0;
			bir_q    <= '0;
			nib_q    <= '0;
			have_q   <= 1'b0;
			any_q    <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bhd_pkg::CFG_GLYPH_WIDTH: width_q <= cfg_wdata;
					bhd_pkg::CFG_GLYPH_HEIGHT: height_q <= cfg_wdata[HW-1:0];
				endcase
			end
			if (accept) begin
				row_q  <= row_n;
				bir_q  <= bir_n;
				nib_q  <= nib_n;
				have_q <= have_n;
				any_q  <= any_n;
				err_q  <= err_n;
			end
		end
	end

endmodule

FILE: design/bhd_queue.sv
// ----------------------------------------------------------------------------
// bhd_queue - command queue
// Short first-in first-out buffer between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module bhd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bhd_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output bhd_pkg::cmd_t head,
	output logic          empty
);

	localparam int PW = bhd_pkg::QPTR_W;

	bhd_pkg::cmd_t    mem_q [bhd_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      fill_q;

	assign full  = (fill_q == (PW + 1)'(bhd_pkg::QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10: fill_q <= fill_q + (PW + 1)'(1);
				2'b01: fill_q <= fill_q - (PW + 1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

FILE: design/bhd_back.sv
// ----------------------------------------------------------------------------
// bhd_back - output sequencer
// Expands each queued command into its run of bytes and drives the output
// register of the result stream.
// ----------------------------------------------------------------------------
module bhd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  bhd_pkg::cmd_t                  head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bhd_pkg::TDATA_W-1:0]    m_tdata,   // out_byte, total_bytes
	output logic                           m_tlast,
	output logic [1:0]                     m_tuser    // blank, error
);

	localparam int CW = bhd_pkg::CNT_W;
	localparam int PAD_W = bhd_pkg::TDATA_W - bhd_pkg::BYTE_W - bhd_pkg::TOTAL_W;

	logic [CW-1:0] cnt_q;
	logic          load;
	logic          final_item;

	assign load       = !q_empty && (!m_tvalid || m_tready);
	assign final_item = (cnt_q + CW'(1)) >= head.count;
	assign pop        = load && final_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= final_item ? '0 : cnt_q + CW'(1);
			end
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// flags and total ride only on the last byte of a run
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {PAD_W'(0), (final_item ? head.total : '0), head.data};
			m_tlast <= final_item && head.fin;
			m_tuser <= {final_item && head.error, final_item && head.blank};
		end
	end

`ifndef ASSERT_OFF
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tlast)
		else $error("error result without last");
	a_run_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> !q_empty)
		else $error("run in progress with no command queued");
`endif

endmodule

FILE: verif/bdf_hex_bitmap_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdf_hex_bitmap_decoder_tb - self-checking bench for the glyph hex decoder
// Streams glyph bitmap text into the decoder under several width and height
// settings and predicts every output byte, its flags and the glyph total.
// Each output is checked against the oldest predicted byte. The sender idles
// in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module bdf_hex_bitmap_decoder_tb;

	localparam int ROW_BYTES_MAX = 32;
	localparam int ALIGN         = 4;

	typedef struct packed {
		logic [bhd_pkg::BYTE_W-1:0]  data;
		logic                        last;
		logic                        blank;
		logic                        err;
		logic [bhd_pkg::TOTAL_W-1:0] total;
	} glyph_byte_t;

	class glyph_scoreboard;
		logic [bhd_pkg::WIDTH_W-1:0]  width;
		logic [bhd_pkg::HEIGHT_W-1:0] height;
		logic [7:0]                   row_index;
		logic [5:0]                   byte_in_row;
		logic [3:0]                   high_nib;
		bit                           have_nib;
		bit                           any_set;
		bit                           err_latched;
		glyph_byte_t                  expected_bytes[$];
		int                           failures;

		function new();
			width = bhd_pkg::WIDTH_RESET;
			height = bhd_pkg::HEIGHT_RESET;
			failures = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			row_index = '0;
			byte_in_row = '0;
			high_nib = '0;
			have_nib = 0;
			any_set = 0;
			err_latched = 0;
		endfunction

		function void write_reg(logic [bhd_pkg::CFG_IDX_W-1:0] idx,
				logic [bhd_pkg::CFG_DATA_W-1:0] v);
			if (idx == bhd_pkg::CFG_GLYPH_WIDTH) begin
				width = v;
			end else begin
				height = v[bhd_pkg::HEIGHT_W-1:0];
			end
		endfunction

		function int row_bytes();
			int rb;
			rb = (int'(width) + 7) >> 3;
			if (rb < 1) rb = 1;
			if (rb > ROW_BYTES_MAX) rb = ROW_BYTES_MAX;
			return rb;
		endfunction

		function int stride();
			int rb;
			rb = row_bytes();
			return rb + (ALIGN - rb % ALIGN) % ALIGN;
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= bhd_pkg::CH_ZERO && c <= bhd_pkg::CH_NINE)
				return int'(c - bhd_pkg::CH_ZERO);
			if (c >= bhd_pkg::CH_UPPER_A && c <= bhd_pkg::CH_UPPER_F)
				return int'(c - bhd_pkg::CH_UPPER_A) + 10;
			if (c >= bhd_pkg::CH_LOWER_A && c <= bhd_pkg::CH_LOWER_F)
				return int'(c - bhd_pkg::CH_LOWER_A) + 10;
			return -1;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(logic [7:0] v, bit fin, int total);
			glyph_byte_t e;
			e.data = v;
			e.last = fin;
			e.blank = fin && !any_set;
			e.err = 1'b0;
			e.total = fin ? bhd_pkg::TOTAL_W'(total) : '0;
			expected_bytes.push_back(e);
		endfunction

		function void raise_error();
			glyph_byte_t e;
			err_latched = 1;
			have_nib = 0;
			e = '0;
			e.last = 1'b1;
			e.err = 1'b1;
			expected_bytes.push_back(e);
		endfunction

		// one accepted request: update the parse state and queue what it produces
		function void note_char(logic [7:0] c, logic f);
			int rb, st, total, hv;
			bit last_row, fin;
			logic [7:0] v;
			if (f) clear_parse();
			if (err_latched || row_index >= height) return;
			rb = row_bytes();
			st = stride();
			total = (int'(height) * st) & 'h1FFF;
			last_row = (int'(row_index) + 1 == int'(height));
			if (c == bhd_pkg::CH_NEWLINE) begin
				// lone digit before the newline counts as a bad character
				if (have_nib) begin
					raise_error();
					return;
				end
				for (int k = int'(byte_in_row); k < st; k++)
					push_byte(8'h00, last_row && (k + 1 == st), total);
				row_index++;
				byte_in_row = '0;
				return;
			end
			if (int'(byte_in_row) >= rb) return;
			hv = hex_value(c);
			if (hv < 0) begin
				raise_error();
				return;
			end
			if (!have_nib) begin
				high_nib = hv[3:0];
				have_nib = 1;
				return;
			end
			v = {high_nib, hv[3:0]};
			have_nib = 0;
			if (v != 8'h00) any_set = 1;
			byte_in_row++;
			fin = last_row && (int'(byte_in_row) >= st);
			push_byte(v, fin, total);
			if (fin) begin
				row_index++;
				byte_in_row = '0;
			end
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10) $display("%t: %s", $realtime, msg);
		endfunction

		function void check_byte(logic [bhd_pkg::TDATA_W-1:0] td, logic tl, logic [1:0] tu);
			glyph_byte_t got, want;
			got.data = td[bhd_pkg::BYTE_W-1:0];
			got.total = td[bhd_pkg::BYTE_W +: bhd_pkg::TOTAL_W];
			got.last = tl;
			got.blank = tu[0];
			got.err = tu[1];
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b blank %0b error %0b total %0d",
					got.data, got.last, got.blank, got.err, got.total));
				return;
			end
			want = expected_bytes.pop_front();
			if (got !== want)
				report($sformatf({"mismatch: expected byte %02h last %0b blank %0b error %0b ",
					"total %0d, got byte %02h last %0b blank %0b error %0b total %0d"},
					want.data, want.last, want.blank, want.err, want.total,
					got.data, got.last, got.blank, got.err, got.total));
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bhd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bhd_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [bhd_pkg::CH_W-1:0]       s_tdata;    // ch
	logic                           s_tuser;    // first
	logic                           m_tvalid;
	logic                           m_tready;
	logic [bhd_pkg::TDATA_W-1:0]    m_tdata;    // out_byte, total_bytes
	logic                           m_tlast;
	logic [1:0]                     m_tuser;    // blank, error

	glyph_scoreboard sb;
	int burst_left;
	int sent_count;
	bit glyph_head;

	bdf_hex_bitmap_decoder #(
		.MAX_ROW_BYTES(ROW_BYTES_MAX),
		.STRIDE_ALIGN (ALIGN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("bdf_hex_bitmap_decoder_tb failed");
		$finish;
	end

	// receiver: switches at random among four stall patterns
	initial begin
		int mode, left, phase;
		m_tready = 1'b0;
		mode = 0;
		left = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(40, 300);
			end
			left--;
			phase++;
			case (mode)
				0: m_tready = 1'b1;
				1: m_tready = 1'($urandom_range(0, 1));
				2: m_tready = ($urandom_range(0, 3) == 0);
				default: m_tready = (phase % 7 < 4);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast, m_tuser);
	end

	// sender works in bursts with random gaps between them
	task automatic send_char(input logic [7:0] c, input logic f);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = c;
		s_tuser = f;
		do @(posedge clk); while (!s_tready);
		sb.note_char(c, f);
		sent_count++;
	endtask

	task automatic put_char(input logic [7:0] c);
		send_char(c, glyph_head);
		glyph_head = 0;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return bhd_pkg::CH_ZERO + 8'(n);
		if ($urandom_range(0, 1)) return bhd_pkg::CH_UPPER_A + 8'(n) - 8'd10;
		return bhd_pkg::CH_LOWER_A + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == bhd_pkg::CH_NEWLINE || sb.hex_value(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == bhd_pkg::CH_NEWLINE);
		return c;
	endfunction

	task automatic put_hex_byte(input bit zero);
		logic [7:0] v;
		v = (zero || $urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		put_char(hex_char(v[7:4]));
		put_char(hex_char(v[3:0]));
	endtask

	task automatic send_row(input int rb, input int st, input bit is_last, input bit zero,
			input bit bad);
		int nb;
		if (bad) begin
			repeat ($urandom_range(0, rb - 1)) put_hex_byte(zero);
			if ($urandom_range(0, 1)) begin
				put_char(non_hex_char());
			end else begin
				put_char(hex_char(4'($urandom_range(0, 15))));
				put_char(bhd_pkg::CH_NEWLINE);
			end
			return;
		end
		nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rb - 1) : rb;
		repeat (nb) put_hex_byte(zero);
		// characters past the row width are skipped
		if (nb == rb && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) put_char(text_char());
		// an unpadded full last row already ends the glyph
		if (!(is_last && nb == rb && st == rb && $urandom_range(0, 1)))
			put_char(bhd_pkg::CH_NEWLINE);
	endtask

	task automatic send_glyph();
		int kind, h, rows, rb, st, bad_row;
		bit zero;
		kind = $urandom_range(0, 9);
		h = int'(sb.height);
		rb = sb.row_bytes();
		st = sb.stride();
		zero = ($urandom_range(0, 3) == 0);
		glyph_head = 1;
		if (kind == 9) begin
			put_char(8'($urandom_range(0, 255)));
			repeat ($urandom_range(4, 14))
				send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			return;
		end
		rows = h;
		if (kind == 8 || h > 16) rows = (h == 0) ? 0 : $urandom_range(0, (h > 6) ? 6 : h - 1);
		bad_row = (kind == 7 && rows > 0) ? $urandom_range(0, rows - 1) : -1;
		if (rows == 0) put_char(hex_char(4'($urandom_range(0, 15))));
		for (int r = 0; r < rows; r++) begin
			send_row(rb, st, r + 1 == h, zero, r == bad_row);
			if (r == bad_row) break;
		end
		// text after a finished or failed glyph is ignored
		if ((rows == h || bad_row >= 0) && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_geometry(input int w, input int h);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = bhd_pkg::CFG_GLYPH_WIDTH;
		cfg_wdata = bhd_pkg::CFG_DATA_W'(w);
		@(posedge clk);
		sb.write_reg(bhd_pkg::CFG_GLYPH_WIDTH, bhd_pkg::CFG_DATA_W'(w));
		@(negedge clk);
		cfg_index = bhd_pkg::CFG_GLYPH_HEIGHT;
		cfg_wdata = bhd_pkg::CFG_DATA_W'(h);
		@(posedge clk);
		sb.write_reg(bhd_pkg::CFG_GLYPH_HEIGHT, bhd_pkg::CFG_DATA_W'(h));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int phase_w[9];
		int phase_h[9];
		int phase_start, random_target;
		phase_w = '{0, 1, 511, 9, 17, 40, 24, 64, 8};
		phase_h = '{2, 1, 1, 3, 255, 0, 5, 1, 4};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		burst_left = 0;
		sent_count = 0;
		glyph_head = 0;
		sb = new();
		random_target = 210;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: one byte per row, padded to four
		glyph_head = 1;
		put_char("F");
		put_char("f");
		put_char(bhd_pkg::CH_NEWLINE);
		put_char("0");
		put_char("0");
		put_char(bhd_pkg::CH_NEWLINE);
		put_char(bhd_pkg::CH_NEWLINE);
		put_char("9");
		put_char("a");
		put_char("Z");
		put_char(bhd_pkg::CH_NEWLINE);
		put_char("0");
		put_char("G");
		put_char("7");
		glyph_head = 1;
		put_char("1");
		put_char(bhd_pkg::CH_NEWLINE);

		// aligned single row ends on its last data byte
		set_geometry(32, 1);
		glyph_head = 1;
		repeat (8) put_char("0");
		put_char(bhd_pkg::CH_NEWLINE);
		put_char("A");

		for (int p = 0; p < 9; p++) begin
			set_geometry(phase_w[p], phase_h[p]);
			phase_start = sent_count;
			do send_glyph(); while (sent_count - phase_start < 6);
		end
		while (sent_count < random_target) begin
			set_geometry($urandom_range(0, 40), $urandom_range(0, 4));
			send_glyph();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.failures == 0) begin
			$display("bdf_hex_bitmap_decoder_tb passed");
		end else begin
			$display("bdf_hex_bitmap_decoder_tb failed");
		end
		$finish;
	end

endmodule

FILE: files.f
design/bhd_pkg.sv
design/bhd_front.sv
design/bhd_queue.sv
design/bhd_back.sv
design/bdf_hex_bitmap_decoder.sv
verif/bdf_hex_bitmap_decoder_tb.sv
